>>> rtl/rdc_pkg.sv
// Shared types and constants for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

   // Field widths
   localparam int VALUE_W = 31;
   localparam int RADIX_W = 16;
   localparam int CNT_W   = $clog2(VALUE_W);

   // Default digit stack depth
   localparam int MAX_DIGITS_DEF = 32;

   // Input item
   typedef struct packed {
      logic [VALUE_W-1:0] n_value;
      logic [RADIX_W-1:0] radix;
   } rdc_req_type;

   // Result item
   typedef struct packed {
      logic [RADIX_W-1:0] digit;
      logic               last;
      logic               error;
   } rdc_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture the accepted item, clear the stack
      logic emit_err;  // load the error result into the output register
      logic step;      // one quotient bit of the serial divider
      logic pop;       // read the top of the stack, drop it
      logic emit;      // load the popped digit into the output register
   } rdc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic in_zero;       // incoming value is zero
      logic in_bad_radix;  // incoming radix is below two
      logic last_step;     // this step finishes one division
      logic quot_zero;     // quotient after this step is zero
      logic out_last;      // output register holds the final result
   } rdc_status_type;

endpackage

>>> rtl/rdc_datapath.sv
// Datapath: serial restoring divider, digit stack and output register.
`timescale 1ns / 1ps

module rdc_datapath
   import rdc_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  rdc_req_type    req_data,
   input  rdc_cmd_type    cmd,
   output rdc_status_type status,
   output rdc_rsp_type    rsp_data
);

   localparam int AW = $clog2(MAX_DIGITS);
   localparam int DW = $clog2(MAX_DIGITS + 1);

   // Divider registers: quotient shifts in as the dividend shifts out
   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] radix_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DW-1:0]      depth_ff;

   // Stack and output registers
   logic [RADIX_W-1:0] stack_mem [MAX_DIGITS];
   logic [RADIX_W-1:0] rd_ff;
   logic               rd_last_ff;
   rdc_rsp_type        rsp_ff;

   logic [RADIX_W:0]   trial;
   logic [RADIX_W:0]   diff;
   logic               ge;
   logic [DW-1:0]      depth_m1;
   logic               room;

   // One restoring division step
   always_comb begin
      trial   = {rem_ff, quot_ff[VALUE_W-1]};
      diff    = trial - {1'b0, radix_ff};
      ge      = (trial >= {1'b0, radix_ff});
      rem_in  = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      quot_in = {quot_ff[VALUE_W-2:0], ge};
   end

   assign depth_m1 = depth_ff - 1'b1;
   assign room     = (depth_ff < DW'(MAX_DIGITS));

   // Status back to the controller
   always_comb begin
      status.in_zero      = (req_data.n_value == '0);
      status.in_bad_radix = (req_data.radix[RADIX_W-1:1] == '0);
      status.last_step    = (cnt_ff == '0);
      status.quot_zero    = (quot_in == '0);
      status.out_last     = rsp_ff.last;
   end

   // Divider and stack pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         depth_ff <= '0;
      end else if (cmd.load) begin
         quot_ff  <= req_data.n_value;
         radix_ff <= req_data.radix;
         rem_ff   <= '0;
         cnt_ff   <= CNT_W'(VALUE_W - 1);
         depth_ff <= '0;
      end else if (cmd.step) begin
         quot_ff <= quot_in;
         if (cnt_ff == '0) begin
            // division done: remainder goes on the stack if there is room, restart on quotient
            rem_ff <= '0;
            cnt_ff <= CNT_W'(VALUE_W - 1);
            if (room) begin
               depth_ff <= depth_ff + 1'b1;
            end
         end else begin
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
         end
      end else if (cmd.pop) begin
         depth_ff <= depth_m1;
      end
   end

   // Digit stack memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.step && (cnt_ff == '0) && room) begin
         stack_mem[depth_ff[AW-1:0]] <= rem_in;
      end
      if (cmd.pop) begin
         rd_ff      <= stack_mem[depth_m1[AW-1:0]];
         rd_last_ff <= (depth_ff == DW'(1));
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         rsp_ff.digit <= '0;
         rsp_ff.last  <= 1'b1;
         rsp_ff.error <= 1'b1;
      end else if (cmd.emit) begin
         rsp_ff.digit <= rd_ff;
         rsp_ff.last  <= rd_last_ff;
         rsp_ff.error <= 1'b0;
      end
   end

   assign rsp_data = rsp_ff;

   // Checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(MAX_DIGITS))
      else $error("digit stack depth beyond capacity");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> depth_ff != '0)
      else $error("pop from empty digit stack");

   a_emit_after_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> $past(cmd.pop))
      else $error("digit emitted without a stack read");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(VALUE_W - 1))
      else $error("divider bit counter out of range");

endmodule

>>> rtl/rdc_controller.sv
// Controller: sequences load, division, stack drain and result handshake.
`timescale 1ns / 1ps

module rdc_controller
   import rdc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  rdc_status_type status,
   output rdc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_POP,
      S_LOAD,
      S_WAIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands decoded from state, the incoming request and the datapath status
   always_comb begin
      cmd.load     = accept;
      cmd.emit_err = accept && !status.in_zero && status.in_bad_radix;
      cmd.step     = (state_ff == S_DIV);
      cmd.pop      = (state_ff == S_POP);
      cmd.emit     = (state_ff == S_LOAD);
   end

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept && !status.in_zero) begin
                  if (status.in_bad_radix) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_WAIT;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (status.last_step && status.quot_zero) begin
                  state_ff <= S_POP;
               end
            end
            S_POP: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_WAIT;
            end
            S_WAIT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= status.out_last ? S_IDLE : S_POP;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   // Checks
   a_valid_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_WAIT)
      else $error("result valid outside the wait state");

   a_err_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_err |=> rsp_valid_ff)
      else $error("error result not presented");

   a_drain_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && status.last_step && status.quot_zero |=> cmd.pop)
      else $error("stack drain did not follow the final division");

endmodule

>>> rtl/radix_digit_converter_core.sv
// Top level of the radix digit converter: controller plus datapath.
`timescale 1ns / 1ps

// Converts a 31-bit unsigned value to its digits in a radix of 2 to 65535,
// most significant digit first, one result item per digit, with last set on
// the final digit. A zero value gives no result; a radix of 0 or 1 with a
// nonzero value gives one result with error and last set and digit zero.
// One item is processed at a time. Each digit is the remainder of one division
// in the one-bit-per-cycle restoring divider and is pushed on the digit stack;
// once the quotient reaches zero, each digit is read back from the stack,
// loaded into the output register and presented until the result side takes
// it. Only the MAX_DIGITS least significant digits are kept when a value has
// more digits than the stack holds.
module radix_digit_converter_core
   import rdc_pkg::*;
#(
   parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rdc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rdc_rsp_type rsp_data
);

   rdc_cmd_type    cmd;
   rdc_status_type status;

   rdc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rdc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

>>> tb/sv/tb_radix_digit_converter_core.sv
// Self-checking testbench for the radix digit converter core.
`timescale 1ns / 1ps

module tb_radix_digit_converter_core;
   import rdc_pkg::*;

   localparam int STACK_DEPTH  = MAX_DIGITS_DEF;
   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 100;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rdc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rdc_rsp_type rsp_data;

   // Digits still owed by the block, oldest first
   rdc_rsp_type pending_digits [$];

   int error_count   = 0;
   int items_sent    = 0;
   int digits_seen   = 0;
   int zero_items    = 0;
   int bad_radix     = 0;
   int longest_conv  = 0;
   int input_stalls  = 0;
   int cycle_count   = 0;

   // Idling controls, changed by the tests between items
   bit gaps_on  = 1'b0;
   bit stall_on = 1'b0;
   bit rsp_hold = 1'b0;
   int stall_left = 0;
   event hold_start;

   radix_digit_converter_core #(
      .MAX_DIGITS(STACK_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("timeout after %0d cycles, %0d digits still owed", cycle_count,
               pending_digits.size());
      $display("tb_radix_digit_converter_core: errors");
      $finish;
   end

   // One line per mismatch
   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Expected digits of one conversion, most significant first
   function automatic void convert_to_digits(input rdc_req_type item);
      logic [VALUE_W-1:0] quot;
      logic [RADIX_W-1:0] base;
      logic [RADIX_W-1:0] rems [$];
      rdc_rsp_type        r;
      quot = item.n_value;
      base = item.radix;
      if (quot == '0) begin
         zero_items++;
         return;
      end
      if (base < 16'd2) begin
         bad_radix++;
         r.digit = '0;
         r.last  = 1'b1;
         r.error = 1'b1;
         pending_digits.push_back(r);
         return;
      end
      // remainders least significant first; overflow beyond the stack is dropped
      while (quot != '0) begin
         if (rems.size() < STACK_DEPTH)
            rems.push_back(RADIX_W'(quot % base));
         quot = quot / base;
      end
      if (rems.size() > longest_conv) longest_conv = rems.size();
      for (int i = rems.size() - 1; i >= 0; i--) begin
         r.digit = rems[i];
         r.last  = (i == 0);
         r.error = 1'b0;
         pending_digits.push_back(r);
      end
   endfunction

   // Result checker
   always @(posedge clock) begin
      rdc_rsp_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stalls++;
         if (rsp_valid && !rsp_stall) begin
            digits_seen++;
            if (pending_digits.size() == 0) begin
               report_mismatch($sformatf("unexpected result digit=%0d last=%0b error=%0b",
                               rsp_data.digit, rsp_data.last, rsp_data.error));
            end else begin
               want = pending_digits.pop_front();
               if (rsp_data.digit !== want.digit)
                  report_mismatch($sformatf("digit got %0d want %0d",
                                  rsp_data.digit, want.digit));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last got %0b want %0b (digit %0d)",
                                  rsp_data.last, want.last, want.digit));
               if (rsp_data.error !== want.error)
                  report_mismatch($sformatf("error got %0b want %0b",
                                  rsp_data.error, want.error));
            end
         end
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Long hold-off of the result side, timed here
   always begin
      @(hold_start);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Result side stall pattern
   always @(negedge clock) begin
      if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_on && $urandom_range(0, 9) < 3) stall_left = pick_gap() + 1;
      end
   end

   // Offer one item, hold it until taken, then idle for the given gap
   task automatic send_item(input rdc_req_type item, input int gap);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      convert_to_digits(item);
      items_sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic rdc_req_type make_item(input logic [VALUE_W-1:0] v,
                                             input logic [RADIX_W-1:0] b);
      rdc_req_type it;
      it.n_value = v;
      it.radix   = b;
      return it;
   endfunction

   // Random value with a random bit length, so all digit counts occur
   function automatic logic [VALUE_W-1:0] random_value();
      int                 nbits;
      logic [VALUE_W-1:0] v;
      nbits = $urandom_range(1, VALUE_W);
      v = VALUE_W'($urandom) & ((VALUE_W'(1) << nbits) - VALUE_W'(1));
      v[nbits-1] = 1'b1;
      return v;
   endfunction

   function automatic logic [RADIX_W-1:0] random_radix();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8)  return RADIX_W'($urandom_range(0, 1));
      if (p < 20) return 16'd2;
      if (p < 55) return RADIX_W'($urandom_range(3, 16));
      if (p < 75) return RADIX_W'($urandom_range(17, 255));
      if (p < 95) return RADIX_W'($urandom_range(256, 65535));
      return 16'hFFFF;
   endfunction

   function automatic rdc_req_type random_item();
      if ($urandom_range(0, 19) == 0) return make_item('0, random_radix());
      return make_item(random_value(), random_radix());
   endfunction

   function automatic int item_gap();
      return gaps_on ? pick_gap() : 0;
   endfunction

   // Withdraw the offered item, then wait for every owed digit
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input bit gaps, input bit stalls);
      @(posedge clock);
      gaps_on  = gaps;
      stall_on = stalls;
   endtask

   // Field extremes, zero values, bad radixes and digit edge cases
   task automatic test_directed();
      logic [VALUE_W-1:0] vmax;
      vmax = '1;
      set_idling(1'b1, 1'b1);
      send_item(make_item('0, 16'd0), item_gap());
      send_item(make_item('0, 16'd1), item_gap());
      send_item(make_item('0, 16'd10), item_gap());
      send_item(make_item('0, 16'hFFFF), item_gap());
      send_item(make_item(31'd1, 16'd0), item_gap());
      send_item(make_item(vmax, 16'd1), item_gap());
      send_item(make_item(vmax, 16'd0), item_gap());
      send_item(make_item(31'd1, 16'd2), item_gap());
      send_item(make_item(vmax, 16'd2), item_gap());
      send_item(make_item(31'h4000_0000, 16'd2), item_gap());
      send_item(make_item(vmax, 16'd3), item_gap());
      send_item(make_item(vmax, 16'd10), item_gap());
      send_item(make_item(vmax, 16'd16), item_gap());
      send_item(make_item(vmax, 16'h8000), item_gap());
      send_item(make_item(vmax, 16'hFFFF), item_gap());
      send_item(make_item(31'd65534, 16'hFFFF), item_gap());
      send_item(make_item(31'd65535, 16'hFFFF), item_gap());
      send_item(make_item(31'd9, 16'd10), item_gap());
      send_item(make_item(31'd10, 16'd10), item_gap());
      send_item(make_item(31'd99, 16'd10), item_gap());
      send_item(make_item(31'd100, 16'd10), item_gap());
      send_item(make_item(31'h2AAA_AAAA, 16'h5555), item_gap());
      wait_drained();
   endtask

   // Back-to-back items with no idling on either side
   task automatic test_back_to_back();
      set_idling(1'b0, 1'b0);
      repeat (40) send_item(random_item(), 0);
      wait_drained();
   endtask

   // Result side holds off while items keep coming, so the input stalls
   task automatic test_output_holdoff();
      set_idling(1'b0, 1'b0);
      @(posedge clock);
      -> hold_start;
      repeat (10)
         send_item(make_item(31'($urandom_range(1, 999_999)), 16'd1000), 0);
      wait_drained();
   endtask

   // Random items with idling, pausing now and then until all digits are in
   task automatic test_random();
      set_idling(1'b1, 1'b1);
      for (int n = 0; n < 300; n++) begin
         send_item(random_item(), item_gap());
         if (n % 60 == 59) begin
            wait_drained();
            set_idling(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_back_to_back();
      test_output_holdoff();
      test_random();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d items (%0d zero, %0d bad radix), %0d digits checked",
               items_sent, zero_items, bad_radix, digits_seen);
      $display("longest conversion %0d digits, input held back on %0d cycles",
               longest_conv, input_stalls);
      if (error_count == 0) begin
         $display("tb_radix_digit_converter_core: clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_radix_digit_converter_core: errors");
      end
      $finish;
   end

endmodule
